// File: sv/sgp_pkg.sv
// package for the serial gamepad poller: poll phases, result record, port widths
// no dependencies; imported by every module of the poller
`timescale 1ns / 1ps

package sgp_pkg;

	localparam int LINES_W     = 4;
	localparam int SLOT_PORTS  = 4;
	localparam int BTN_W       = 16;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;
	localparam int IN_USED_W   = 1 + LINES_W;

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_SAMPLE_FIRST = 3'd1,
		PH_HOLD         = 3'd2,
		PH_DROP_LATCH   = 3'd3,
		PH_SETTLE       = 3'd4,
		PH_CLOCK_RISE   = 3'd5,
		PH_CLOCK_SAMPLE = 3'd6
	} sgp_phase_t;

	// one input tick
	typedef struct packed {
		logic [LINES_W-1:0] lines;
		logic               start;
	} sgp_tick_t;

	// one result, lowest field last so it lands in bit 0
	typedef struct packed {
		logic [SLOT_PORTS-1:0][BTN_W-1:0] buttons;
		logic                             done;
		logic                             busy;
		logic                             clock;
		logic                             latch;
	} sgp_result_t;

	localparam int RES_W = $bits(sgp_result_t);

endpackage

// File: sv/sgp_in_reg.sv
// input register of the serial gamepad poller: holds one tick request
// depends on sgp_pkg
`timescale 1ns / 1ps

module sgp_in_reg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sgp_pkg::IN_TDATA_W-1:0]   in_data,
	output logic                             valid_s1,
	output sgp_pkg::sgp_tick_t               tick_s1,
	input  logic                             take
);
	import sgp_pkg::*;

	logic vld_q;
	sgp_tick_t tick_q;

	assign in_ready = !vld_q || take;
	assign valid_s1 = vld_q;
	assign tick_s1  = tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_q <= sgp_tick_t'(in_data[IN_USED_W-1:0]);
		end
	end

endmodule

// File: sv/sgp_core.sv
// poll sequencer of the serial gamepad poller: phase machine, bit counter, capture shifters
// depends on sgp_pkg
`timescale 1ns / 1ps

module sgp_core #(
	parameter int SLOTS = 4,
	parameter int BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  sgp_pkg::sgp_tick_t   tick,
	output sgp_pkg::sgp_result_t res
);
	import sgp_pkg::*;

	localparam int CNT_W = $clog2(BITS + 1);
	localparam int EXT_W = (SLOTS > LINES_W) ? SLOTS : LINES_W;
	localparam int CAP_W = (BITS > BTN_W) ? BITS : BTN_W;

	sgp_phase_t        phase_q, phase_d;
	logic [CNT_W-1:0]  bitcnt_q;
	logic [BITS-1:0]   capture_q [SLOTS];
	logic              latch_q, clock_q;

	logic              latch_d, clock_d;
	logic              do_clear, do_sample, done;
	logic [EXT_W-1:0]  lines_ext;
	logic              cnt_full;

	assign lines_ext = EXT_W'(tick.lines);
	assign cnt_full  = (bitcnt_q >= CNT_W'(BITS));

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE:         if (tick.start) phase_d = PH_SAMPLE_FIRST;
			PH_SAMPLE_FIRST: phase_d = PH_HOLD;
			PH_HOLD:         phase_d = PH_DROP_LATCH;
			PH_DROP_LATCH:   phase_d = PH_SETTLE;
			PH_SETTLE:       phase_d = PH_CLOCK_RISE;
			PH_CLOCK_RISE:   phase_d = cnt_full ? PH_IDLE : PH_CLOCK_SAMPLE;
			PH_CLOCK_SAMPLE: phase_d = PH_CLOCK_RISE;
			default:         phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		latch_d   = latch_q;
		clock_d   = clock_q;
		do_clear  = 1'b0;
		do_sample = 1'b0;
		done      = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (tick.start) begin
					do_clear = 1'b1;
					latch_d  = 1'b1;
					clock_d  = 1'b0;
				end
			end
			PH_SAMPLE_FIRST: do_sample = 1'b1;
			PH_HOLD:         ;
			PH_DROP_LATCH:   latch_d = 1'b0;
			PH_SETTLE:       ;
			PH_CLOCK_RISE: begin
				if (cnt_full) begin
					done = 1'b1;
				end else begin
					clock_d = 1'b1;
				end
			end
			PH_CLOCK_SAMPLE: begin
				do_sample = 1'b1;
				clock_d   = 1'b0;
			end
			default: begin
				latch_d = 1'b0;
				clock_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bitcnt_q <= '0;
			latch_q  <= 1'b0;
			clock_q  <= 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				capture_q[s] <= '0;
			end
		end else if (adv) begin
			phase_q <= phase_d;
			latch_q <= latch_d;
			clock_q <= clock_d;
			if (do_clear) begin
				bitcnt_q <= '0;
			end else if (do_sample) begin
				bitcnt_q <= bitcnt_q + 1'b1;
			end
			for (int s = 0; s < SLOTS; s++) begin
				if (do_clear) begin
					capture_q[s] <= '0;
				end else if (do_sample) begin
					// lines are active low, store pressed as 1
					capture_q[s] <= {capture_q[s][BITS-2:0], ~lines_ext[s]};
				end
			end
		end
	end

	// done comes only from the clock rise phase, where the capture is not shifting
	assign res.latch = latch_d;
	assign res.clock = clock_d;
	assign res.busy  = (phase_d != PH_IDLE);
	assign res.done  = done;

	for (genvar g = 0; g < SLOT_PORTS; g++) begin : g_btn
		if (g < SLOTS) begin : g_have
			logic [CAP_W-1:0] cap_ext;
			assign cap_ext           = CAP_W'(capture_q[g]);
			assign res.buttons[g]    = done ? cap_ext[BTN_W-1:0] : '0;
		end else begin : g_none
			assign res.buttons[g] = '0;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done |-> !res.busy && !res.clock && !res.latch)
		else $error("done with lines or busy still active");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done |-> bitcnt_q == CNT_W'(BITS))
		else $error("poll finished with wrong bit count");

	a_lines_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(latch_q && clock_q))
		else $error("latch and clock high together");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q <= CNT_W'(BITS))
		else $error("bit counter past limit");

	a_start_latch: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == PH_IDLE && tick.start |=> latch_q && bitcnt_q == '0)
		else $error("start did not raise latch and clear counter");

endmodule

// File: sv/sgp_out_reg.sv
// result register of the serial gamepad poller: one registered result toward the output stream
// depends on sgp_pkg
`timescale 1ns / 1ps

module sgp_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  sgp_pkg::sgp_result_t            res,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sgp_pkg::OUT_TDATA_W-1:0] out_data,
	output logic                            can_load
);
	import sgp_pkg::*;

	logic        vld_q;
	sgp_result_t res_q;

	assign can_load  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data  = OUT_TDATA_W'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (can_load) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res;
		end
	end

endmodule

// File: sv/serial_gamepad_poller_top.sv
// top level of the serial gamepad poller: input register, poll sequencer, result register
// depends on sgp_pkg, sgp_in_reg, sgp_core, sgp_out_reg
//
// channel   dir  tdata fields (low bit up)
// s_axis    in   start_req[0], data_lines[4:1], zero pad to 8 bits
// m_axis    out  latch_level[0], clock_level[1], busy_res[2], done_res[3],
//                slot0..slot3_buttons[19:4],[35:20],[51:36],[67:52], zero pad to 72
//
// one tick request in, one result out; a request can be taken every cycle while m_axis is not stalled
// a request passes through the input register, then the phase logic into the result register
// a full poll spans 2 * BITS + 4 ticks from start to done
// arst_n clears the phase machine, counter, captures and both valid flags
// a stalled m_axis holds its result; s_axis keeps taking while the result register frees
`timescale 1ns / 1ps

module serial_gamepad_poller_top #(
	parameter int SLOTS = 4,
	parameter int BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// start_req, data_lines[3:0]
	input  logic [sgp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// latch_level, clock_level, busy_res, done_res, slot0..slot3_buttons[15:0]
	output logic [sgp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import sgp_pkg::*;

	logic        valid_s1;
	sgp_tick_t   tick_s1;
	logic        can_load;
	logic        adv;
	sgp_result_t res;

	assign adv = valid_s1 && can_load;

	sgp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.valid_s1 (valid_s1),
		.tick_s1  (tick_s1),
		.take     (adv)
	);

	sgp_core #(
		.SLOTS (SLOTS),
		.BITS  (BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tick   (tick_s1),
		.res    (res)
	);

	sgp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.can_load  (can_load)
	);

endmodule
